// ===== rtl/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared constants, types and phase tables for the four-bit LCD write
// sequencer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

    localparam int WAIT_BITS_DEFAULT = 16;
    localparam int CFG_BITS          = 16;
    localparam int PADDR_BITS        = 3;

    localparam logic [CFG_BITS-1:0] LONG_WAIT_RESET  = 16'd2000;
    localparam logic [CFG_BITS-1:0] SHORT_WAIT_RESET = 16'd20;

    // Register indexes on the configuration port
    localparam logic REG_LONG_WAIT  = 1'b0;
    localparam logic REG_SHORT_WAIT = 1'b1;

    // Request codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WCMD  = 2'd1;
    localparam logic [1:0] CMD_WDATA = 2'd2;
    localparam logic [1:0] CMD_INIT  = 2'd3;

    // Parts of one nibble transfer
    localparam logic [1:0] PART_SET    = 2'd0;
    localparam logic [1:0] PART_STROBE = 2'd1;
    localparam logic [1:0] PART_HOLD   = 2'd2;

    localparam logic [5:0] LAST_INIT_PHASE  = 6'd36;
    localparam logic [5:0] LAST_WRITE_PHASE = 6'd5;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_FOUR  = 4'h2;

    localparam logic [3:0][7:0] INIT_BYTES = {8'h06, 8'h01, 8'h0C, 8'h28};

    typedef struct packed {
        logic       first;     // initial all-low wait
        logic       pre;       // wake-up nibble
        logic       pre_two;   // wake-up nibble is 2 rather than 3
        logic [1:0] bsel;      // init byte select
        logic       hi;        // high nibble of the byte
        logic [1:0] part;
    } phase_ent_t;

    typedef phase_ent_t [63:0] phase_tab_t;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable;
        logic       busy_res;
        logic       rejected;
    } result_t;

    function automatic phase_tab_t init_table();
        phase_tab_t tab;
        int         k;
        tab = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (i == 0)
            begin
                tab[i].first = 1'b1;
            end
            else if (i <= 12)
            begin
                k = i - 1;
                tab[i].pre     = 1'b1;
                tab[i].pre_two = ((k / 3) >= 3);
                tab[i].part    = 2'(k % 3);
            end
            else
            begin
                k = i - 13;
                tab[i].bsel = 2'((k / 6) & 3);
                tab[i].hi   = ((k % 6) < 3);
                tab[i].part = 2'(k % 3);
            end
        end
        return tab;
    endfunction

    function automatic phase_tab_t write_table();
        phase_tab_t tab;
        tab = '0;
        for (int i = 0; i < 64; i++)
        begin
            tab[i].hi   = ((i % 6) < 3);
            tab[i].part = 2'(i % 3);
        end
        return tab;
    endfunction

    localparam phase_tab_t INIT_TAB  = init_table();
    localparam phase_tab_t WRITE_TAB = write_table();

endpackage

// ===== rtl/lcdw_phase.sv =====
// ----------------------------------------------------------------------------
// lcdw_phase
// Pin levels and wait count for the phase that is being entered.
// ----------------------------------------------------------------------------
module lcdw_phase #(
    parameter int WAIT_BITS = lcdw_pkg::WAIT_BITS_DEFAULT
) (
    input  logic                          init_mode,
    input  logic [5:0]                    idx,
    input  logic [7:0]                    byte_val,
    input  logic                          sel,
    input  logic [lcdw_pkg::CFG_BITS-1:0] long_wait,
    input  logic [lcdw_pkg::CFG_BITS-1:0] short_wait,
    output logic [5:0]                    pins,
    output logic [WAIT_BITS-1:0]          wait_load
);

    localparam logic [31:0] MAX_WAIT =
        (WAIT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WAIT_BITS) - 32'd1);

    lcdw_pkg::phase_ent_t          ent;
    logic [7:0]                    cur_byte;
    logic [3:0]                    nib;
    logic                          rs;
    logic [lcdw_pkg::CFG_BITS-1:0] w_sel;
    logic [lcdw_pkg::CFG_BITS-1:0] w_eff;
    logic [31:0]                   w_ext;

    always_comb
    begin
        ent      = init_mode ? lcdw_pkg::INIT_TAB[idx] : lcdw_pkg::WRITE_TAB[idx];
        cur_byte = init_mode ? lcdw_pkg::INIT_BYTES[ent.bsel] : byte_val;
        rs       = init_mode ? 1'b0 : sel;
        if (ent.pre)
            nib = ent.pre_two ? lcdw_pkg::NIB_FOUR : lcdw_pkg::NIB_WAKE;
        else
            nib = ent.hi ? cur_byte[7:4] : cur_byte[3:0];

        if (ent.first)
        begin
            pins  = 6'd0;
            w_sel = long_wait;
        end
        else
        begin
            pins  = {rs, (ent.part == lcdw_pkg::PART_STROBE), nib};
            w_sel = (ent.part == lcdw_pkg::PART_HOLD) ? long_wait : short_wait;
        end

        // zero wait still holds the phase for one tick; clamp to counter range
        w_eff     = (w_sel == '0) ? lcdw_pkg::CFG_BITS'(1) : w_sel;
        w_ext     = 32'(w_eff);
        wait_load = (w_ext > MAX_WAIT) ? MAX_WAIT[WAIT_BITS-1:0] : w_ext[WAIT_BITS-1:0];
    end

endmodule

// ===== rtl/lcdw_core.sv =====
// ----------------------------------------------------------------------------
// lcdw_core
// Sequencer state: phase index, wait counter, held byte and pin levels.
// Advances by one tick on every transfer and forms that transfer's result.
// ----------------------------------------------------------------------------
module lcdw_core #(
    parameter int WAIT_BITS = lcdw_pkg::WAIT_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [1:0]                    cmd,
    input  logic [7:0]                    byte_value,
    input  logic [lcdw_pkg::CFG_BITS-1:0] long_wait,
    input  logic [lcdw_pkg::CFG_BITS-1:0] short_wait,
    output lcdw_pkg::result_t             res
);

    logic [5:0]           phase_reg,   phase_next;
    logic [WAIT_BITS-1:0] wait_reg,    wait_next;
    logic [7:0]           byte_reg,    byte_next;
    logic                 sel_reg,     sel_next;
    logic                 init_reg,    init_next;
    logic                 active_reg,  active_next;
    logic [5:0]           pins_reg,    pins_next;

    logic                 dec_init;
    logic [5:0]           dec_idx;
    logic [7:0]           dec_byte;
    logic                 dec_sel;
    logic [5:0]           dec_pins;
    logic [WAIT_BITS-1:0] dec_wait;
    logic                 start;
    logic                 advance;
    logic                 finish;
    logic [5:0]           last_phase;

    lcdw_phase #(
        .WAIT_BITS (WAIT_BITS)
    ) u_phase (
        .init_mode  (dec_init),
        .idx        (dec_idx),
        .byte_val   (dec_byte),
        .sel        (dec_sel),
        .long_wait  (long_wait),
        .short_wait (short_wait),
        .pins       (dec_pins),
        .wait_load  (dec_wait)
    );

    always_comb
    begin
        last_phase = init_reg ? lcdw_pkg::LAST_INIT_PHASE : lcdw_pkg::LAST_WRITE_PHASE;
        finish     = active_reg && (wait_reg <= WAIT_BITS'(1)) && (phase_reg >= last_phase);
        advance    = active_reg && (wait_reg <= WAIT_BITS'(1)) && (phase_reg < last_phase);
        start      = !active_reg && (cmd != lcdw_pkg::CMD_TICK);

        // one decoder serves both a fresh start and the next phase
        if (start)
        begin
            dec_init = (cmd == lcdw_pkg::CMD_INIT);
            dec_idx  = 6'd0;
            dec_byte = (cmd == lcdw_pkg::CMD_INIT) ? byte_reg : byte_value;
            dec_sel  = (cmd == lcdw_pkg::CMD_WDATA);
        end
        else
        begin
            dec_init = init_reg;
            dec_idx  = phase_reg + 6'd1;
            dec_byte = byte_reg;
            dec_sel  = sel_reg;
        end

        phase_next  = phase_reg;
        wait_next   = wait_reg;
        byte_next   = byte_reg;
        sel_next    = sel_reg;
        init_next   = init_reg;
        active_next = active_reg;
        pins_next   = pins_reg;

        if (finish)
        begin
            active_next = 1'b0;
            wait_next   = '0;
        end
        else if (advance)
        begin
            phase_next = dec_idx;
            wait_next  = dec_wait;
            pins_next  = dec_pins;
        end
        else if (active_reg)
        begin
            wait_next = wait_reg - WAIT_BITS'(1);
        end

        if (start)
        begin
            init_next   = dec_init;
            byte_next   = dec_byte;
            sel_next    = dec_sel;
            phase_next  = 6'd0;
            active_next = 1'b1;
            wait_next   = dec_wait;
            pins_next   = dec_pins;
        end

        res.data_nibble = pins_next[3:0];
        res.enable      = pins_next[4];
        res.reg_select  = pins_next[5];
        res.busy_res    = active_next;
        res.rejected    = active_reg && (cmd != lcdw_pkg::CMD_TICK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            wait_reg   <= '0;
            byte_reg   <= '0;
            sel_reg    <= 1'b0;
            init_reg   <= 1'b0;
            active_reg <= 1'b0;
            pins_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            byte_reg   <= byte_next;
            sel_reg    <= sel_next;
            init_reg   <= init_next;
            active_reg <= active_next;
            pins_reg   <= pins_next;
        end
    end

    // idle means a cleared counter, running means a nonzero one
    a_idle_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (wait_reg == '0))
        else $error("wait counter nonzero while idle");

    a_active_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (wait_reg != '0))
        else $error("wait counter reached zero during a sequence");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && active_reg && (wait_reg > WAIT_BITS'(1))
        |=> active_reg && (wait_reg == $past(wait_reg) - WAIT_BITS'(1)))
        else $error("wait counter did not step down");

    a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && active_reg && !init_reg && (wait_reg <= WAIT_BITS'(1))
        && (phase_reg >= lcdw_pkg::LAST_WRITE_PHASE)
        |=> !active_reg && !pins_reg[4])
        else $error("byte write did not end with enable low");

endmodule

// ===== rtl/lcd_four_bit_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_four_bit_write_sequencer
// Timed four-bit write sequencer for the six pins of a character LCD.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   cmd, byte_value
//   out      output     out_valid / out_stall data_nibble, reg_select,
//                                             enable, busy_res, rejected
//   cfg      input      APB psel/penable      long_wait (0x0), short_wait (0x4)
//
// Every input transfer is one tick and yields one registered result in the next cycle.
// A transfer is taken in every cycle in which in_stall is low; the sequencer
// state loop closes within the core and the result register parts the two channels.
// in_stall is high only while a result waits and out_stall is high.
// Reset clears the core pin register and idles the sequencer; waits take defaults.
// ----------------------------------------------------------------------------
module lcd_four_bit_write_sequencer #(
    parameter int WAIT_BITS = lcdw_pkg::WAIT_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [7:0]                      byte_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [3:0]                      data_nibble,
    output logic                            reg_select,
    output logic                            enable,
    output logic                            busy_res,
    output logic                            rejected,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcdw_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [lcdw_pkg::CFG_BITS-1:0] long_wait_reg,  long_wait_next;
    logic [lcdw_pkg::CFG_BITS-1:0] short_wait_reg, short_wait_next;
    logic                          out_valid_reg,  out_valid_next;
    lcdw_pkg::result_t             res_reg;
    lcdw_pkg::result_t             step_res;
    logic                          accept;
    logic                          cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        long_wait_next  = long_wait_reg;
        short_wait_next = short_wait_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                lcdw_pkg::REG_LONG_WAIT:  long_wait_next  = pwdata[lcdw_pkg::CFG_BITS-1:0];
                lcdw_pkg::REG_SHORT_WAIT: short_wait_next = pwdata[lcdw_pkg::CFG_BITS-1:0];
                default:                  long_wait_next  = long_wait_reg;
            endcase
        end

        case (paddr[2])
            lcdw_pkg::REG_LONG_WAIT:  prdata = 32'(long_wait_reg);
            lcdw_pkg::REG_SHORT_WAIT: prdata = 32'(short_wait_reg);
            default:                  prdata = 32'd0;
        endcase

        // hold a waiting result, load a fresh one on each transfer
        out_valid_next = accept || in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_wait_reg  <= lcdw_pkg::LONG_WAIT_RESET;
            short_wait_reg <= lcdw_pkg::SHORT_WAIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            long_wait_reg  <= long_wait_next;
            short_wait_reg <= short_wait_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= step_res;
    end

    lcdw_core #(
        .WAIT_BITS (WAIT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .cmd        (cmd),
        .byte_value (byte_value),
        .long_wait  (long_wait_reg),
        .short_wait (short_wait_reg),
        .res        (step_res)
    );

    assign out_valid   = out_valid_reg;
    assign data_nibble = res_reg.data_nibble;
    assign reg_select  = res_reg.reg_select;
    assign enable      = res_reg.enable;
    assign busy_res    = res_reg.busy_res;
    assign rejected    = res_reg.rejected;

endmodule
